[sv/mbps_pkg.sv]
// ----------------------------------------------------------------------------
// mbps_pkg: shared definitions for the masked byte pattern search
// Sizes, register codes and the structs passed between the search modules.
// ----------------------------------------------------------------------------
package mbps_pkg;

    // Sizing of the pattern window and the region byte counter.
    localparam int MAX_PATTERN_BYTES = 16;
    localparam int REGION_COUNT_BITS = 32;
    localparam int WIN_DEPTH         = 16;
    localparam int LEN_W             = 5;
    localparam int ADDR_W            = 64;
    localparam int CARE_W            = 16;
    localparam int CFG_INDEX_W       = 3;

    // Longest pattern actually compared: bounded by the window depth.
    localparam int EFF_CAP = (MAX_PATTERN_BYTES > WIN_DEPTH) ? WIN_DEPTH :
                             ((MAX_PATTERN_BYTES < 1) ? 1 : MAX_PATTERN_BYTES);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_CARE_BITS      = 3'd2,
        REG_PATTERN_LENGTH = 3'd3,
        REG_REGION_BASE    = 3'd4
    } cfg_reg_t;

    // Configuration as seen by the search core.
    typedef struct packed {
        logic [WIN_DEPTH-1:0][7:0] pattern;
        logic [CARE_W-1:0]         care;
        logic [LEN_W-1:0]          length;
        logic [ADDR_W-1:0]         base;
    } cfg_t;

    // Result of one item in the search stage.
    typedef struct packed {
        logic              emit;
        logic              found;
        logic [ADDR_W-1:0] addr;
    } result_t;

endpackage

[sv/masked_byte_pattern_search.sv]
// Each result is registered in the result register when its item leaves the search stage.
// Throughput: one byte per cycle; the compare stage and the output register
// advance together, and the stage stalls only when a due result cannot be
// placed because the output register is still held.
// Reset (rst_n, asynchronous, active low) empties both stages, clears the
// window and counter, and sets the registers to zero with a length of one.
// ----------------------------------------------------------------------------
// masked_byte_pattern_search: streaming masked byte pattern search
// Bytes of a region enter one per item; the first masked match or the end of
// the region yields one result item with the found flag and match address.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       data_byte,
    input  logic                             last_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             found,
    output logic [63:0]                      match_address
);
    import mbps_pkg::*;

    cfg_t              cfg;
    result_t           res;
    logic              stage_valid_reg;
    logic [7:0]        stage_data_reg;
    logic              stage_last_reg;
    logic              out_valid_reg;
    logic              found_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              out_free;
    logic              stage_go;

    // Configuration registers.
    mbps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Window, counter and compare for the item in the search stage.
    mbps_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (stage_go),
        .data_byte (stage_data_reg),
        .last_byte (stage_last_reg),
        .cfg       (cfg),
        .res       (res)
    );

    // Stage handshake: the stage moves on unless its result has no room.
    assign out_free = !out_valid_reg || out_ready;
    assign stage_go = stage_valid_reg && (!res.emit || out_free);
    assign in_ready = !stage_valid_reg || stage_go;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_data_reg <= data_byte;
            stage_last_reg <= last_byte;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_go && res.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && res.emit)
        begin
            found_reg <= res.found;
            addr_reg  <= res.addr;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign match_address = addr_reg;

endmodule

[sv/mbps_cfg.sv]
// ----------------------------------------------------------------------------
// mbps_cfg: configuration registers
// Holds the pattern, care bits, length and region base, and derives the
// effective pattern length used by the compare.
// ----------------------------------------------------------------------------
module mbps_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                     cfg_data,
    output mbps_pkg::cfg_t                  cfg
);
    import mbps_pkg::*;

    logic [63:0]       pattern_low_reg;
    logic [63:0]       pattern_high_reg;
    logic [CARE_W-1:0] care_reg;
    logic [LEN_W-1:0]  length_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [LEN_W-1:0]  eff_length;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Register writes by index; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            care_reg         <= '0;
            length_reg       <= LEN_W'(1);
            base_reg         <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:    pattern_low_reg  <= cfg_data;
                REG_PATTERN_HIGH:   pattern_high_reg <= cfg_data;
                REG_CARE_BITS:      care_reg         <= cfg_data[CARE_W-1:0];
                REG_PATTERN_LENGTH: length_reg       <= cfg_data[LEN_W-1:0];
                REG_REGION_BASE:    base_reg         <= cfg_data;
                default:            ;
            endcase
        end
    end

    // A length of zero counts as one; lengths past the window are clipped.
    always_comb
    begin
        eff_length = length_reg;
        if (length_reg == '0)
        begin
            eff_length = LEN_W'(1);
        end
        else if (length_reg > LEN_W'(EFF_CAP))
        begin
            eff_length = LEN_W'(EFF_CAP);
        end
    end

    assign cfg.pattern = {pattern_high_reg, pattern_low_reg};
    assign cfg.care    = care_reg;
    assign cfg.length  = eff_length;
    assign cfg.base    = base_reg;

endmodule

[sv/mbps_core.sv]
// ----------------------------------------------------------------------------
// mbps_core: sliding window and masked compare
// Keeps the last bytes of the region, the byte count and the reported flag,
// and decides for the item in the search stage whether a result is due.
// ----------------------------------------------------------------------------
module mbps_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  mbps_pkg::cfg_t      cfg,
    output mbps_pkg::result_t   res
);
    import mbps_pkg::*;

    logic [WIN_DEPTH-1:0][7:0]      window_reg;
    logic [WIN_DEPTH-1:0][7:0]      window_shift;
    logic [REGION_COUNT_BITS-1:0]   seen_reg;
    logic [REGION_COUNT_BITS-1:0]   seen_next;
    logic                           reported_reg;
    logic                           comparable;
    logic                           mismatch;
    logic                           hit;
    logic [REGION_COUNT_BITS-1:0]   len_ext;
    logic [REGION_COUNT_BITS-1:0]   offset;
    logic [3:0]                     pidx;

    // Window with the new byte in front.
    assign window_shift = {window_reg[WIN_DEPTH-2:0], data_byte};

    // Byte counter saturates; a byte seen at saturation is not compared.
    assign comparable = (seen_reg != '1);
    assign seen_next  = comparable ? seen_reg + 1'b1 : seen_reg;
    assign len_ext    = {{(REGION_COUNT_BITS-LEN_W){1'b0}}, cfg.length};

    // Masked compare: window entry j lines up with pattern byte length-1-j.
    always_comb
    begin
        mismatch = 1'b0;
        pidx     = '0;
        for (int j = 0; j < WIN_DEPTH; j++)
        begin
            if (LEN_W'(j) < cfg.length)
            begin
                pidx = 4'(cfg.length - LEN_W'(1) - LEN_W'(j));
                if (cfg.care[pidx] && (cfg.pattern[pidx] != window_shift[j]))
                begin
                    mismatch = 1'b1;
                end
            end
        end
    end

    assign hit    = !reported_reg && comparable && (seen_next >= len_ext) && !mismatch;
    assign offset = seen_next - len_ext;

    // A result is due on a first match or at a region end without one.
    assign res.emit  = hit || (last_byte && !reported_reg);
    assign res.found = hit;
    assign res.addr  = hit ? cfg.base + {{(ADDR_W-REGION_COUNT_BITS){1'b0}}, offset}
                           : '0;

    // Region state; the last byte clears it for the next region.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                window_reg   <= '0;
                seen_reg     <= '0;
                reported_reg <= 1'b0;
            end
            else
            begin
                window_reg   <= window_shift;
                seen_reg     <= seen_next;
                reported_reg <= reported_reg || hit;
            end
        end
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for masked_byte_pattern_search
// Streams byte regions through the search with random sender gaps and
// receiver stalls. Every accepted byte is run through a local model of the
// masked window compare, and each result item is checked in order against it.
// ----------------------------------------------------------------------------
module tb;

    import mbps_pkg::*;

    localparam int CLK_HALF_NS   = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 3;
    localparam int TAIL_STEPS    = 150;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int MAX_REPORTS   = 20;
    localparam int LIMIT_NS      = 3_000_000;

    // One entry of the stimulus plan: a region byte, a register write or a
    // pause until every outstanding result has come back.
    typedef enum logic [1:0] {
        STEP_BYTE,
        STEP_WRITE,
        STEP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t             kind;
        logic [7:0]             data;
        logic                   last;
        logic [CFG_INDEX_W-1:0] index;
        logic [63:0]            value;
    } step_t;

    // One search result item.
    typedef struct {
        logic        found;
        logic [63:0] addr;
    } search_report_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [63:0]            cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             data_byte = '0;
    logic                   last_byte = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   found;
    logic [63:0]            match_address;

    masked_byte_pattern_search i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .match_address (match_address)
    );

    step_t          pending_steps[$];
    search_report_t expected_reports[$];

    // Model copy of the registers and the search state.
    logic [63:0]                  pat_low = '0;
    logic [63:0]                  pat_high = '0;
    logic [CARE_W-1:0]            care_reg = '0;
    logic [LEN_W-1:0]             len_reg = LEN_W'(1);
    logic [63:0]                  base_reg = '0;
    logic [7:0]                   window_q[WIN_DEPTH];
    logic [REGION_COUNT_BITS-1:0] seen_q = '0;
    logic                         reported_q = 1'b0;

    // Registers as the stimulus plan expects them, used to plant patterns.
    logic [63:0]       plan_low = '0;
    logic [63:0]       plan_high = '0;
    logic [CARE_W-1:0] plan_care = '0;
    logic [LEN_W-1:0]  plan_len = LEN_W'(1);

    int mismatch_count = 0;
    int idle_run = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int stall_left = 0;
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int bytes_queued = 0;
    int regions_queued = 0;
    int bytes_taken = 0;
    int writes_taken = 0;
    int hits_seen = 0;
    int misses_seen = 0;

    initial
    begin
        forever #CLK_HALF_NS clk = ~clk;
    end

    initial
    begin
        foreach (window_q[i]) window_q[i] = '0;
    end

    initial
    begin
        #LIMIT_NS;
        $display("masked_byte_pattern_search: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("error at %0t: %s", $realtime, what);
    endtask

    // Length actually compared: zero counts as one, oversize is clipped.
    function automatic int usable_length(input logic [LEN_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > EFF_CAP)
            return EFF_CAP;
        return int'(raw);
    endfunction

    function automatic logic [7:0] pattern_at(input logic [63:0] lo, input logic [63:0] hi,
                                              input int k);
        if (k < 8)
            return lo[8*k +: 8];
        return hi[8*(k-8) +: 8];
    endfunction

    // Shift one byte into the window and work out the result it causes, if any.
    function automatic bit search_step(input logic [7:0] b, input logic last,
                                       output search_report_t rep);
        int len;
        int k;
        bit comparable;
        bit hit;
        bit emit;
        len = usable_length(len_reg);
        comparable = (seen_q != '1);
        emit = 1'b0;
        rep.found = 1'b0;
        rep.addr = '0;
        for (k = WIN_DEPTH - 1; k > 0; k--)
            window_q[k] = window_q[k-1];
        window_q[0] = b;
        if (comparable)
            seen_q++;

        // Oldest window entry lines up with pattern byte zero.
        if (!reported_q && comparable && seen_q >= len)
        begin
            hit = 1'b1;
            for (k = 0; k < len; k++)
                if (care_reg[k] && window_q[len-1-k] != pattern_at(pat_low, pat_high, k))
                    hit = 1'b0;
            if (hit)
            begin
                rep.found = 1'b1;
                rep.addr = base_reg + 64'(seen_q - len);
                reported_q = 1'b1;
                emit = 1'b1;
            end
        end

        // The region ends here: report a miss if nothing matched, then rearm.
        if (last)
        begin
            if (!reported_q)
            begin
                rep.found = 1'b0;
                rep.addr = '0;
                emit = 1'b1;
            end
            for (k = 0; k < WIN_DEPTH; k++)
                window_q[k] = '0;
            seen_q = '0;
            reported_q = 1'b0;
        end
        return emit;
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic last);
        step_t s;
        s.kind = STEP_BYTE;
        s.data = b;
        s.last = last;
        s.index = '0;
        s.value = '0;
        pending_steps.push_back(s);
        bytes_queued++;
    endtask

    task automatic queue_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        step_t s;
        s.kind = STEP_WRITE;
        s.data = '0;
        s.last = 1'b0;
        s.index = idx;
        s.value = value;
        pending_steps.push_back(s);
        case (idx)
            REG_PATTERN_LOW:    plan_low = value;
            REG_PATTERN_HIGH:   plan_high = value;
            REG_CARE_BITS:      plan_care = value[CARE_W-1:0];
            REG_PATTERN_LENGTH: plan_len = value[LEN_W-1:0];
            default:            ;
        endcase
    endtask

    task automatic queue_drain();
        step_t s;
        s.kind = STEP_DRAIN;
        s.data = '0;
        s.last = 1'b0;
        s.index = '0;
        s.value = '0;
        pending_steps.push_back(s);
    endtask

    // A region of random lead bytes, an optional planted pattern (maybe with
    // one cared byte spoiled), and random trailing bytes.
    task automatic queue_region(input int lead, input bit plant, input bit spoil,
                                input int trail);
        logic [7:0] body[$];
        int len;
        int k;
        int pick;
        for (k = 0; k < lead; k++)
            body.push_back(8'($urandom));
        if (plant)
        begin
            len = usable_length(plan_len);
            for (k = 0; k < len; k++)
                body.push_back(plan_care[k] ? pattern_at(plan_low, plan_high, k)
                                            : 8'($urandom));
            if (spoil)
            begin
                pick = $urandom_range(0, len - 1);
                if (plan_care[pick])
                    body[body.size() - len + pick] ^= 8'($urandom_range(1, 255));
            end
        end
        for (k = 0; k < trail; k++)
            body.push_back(8'($urandom));
        if (body.size() == 0)
            body.push_back(8'($urandom));
        foreach (body[i])
            queue_byte(body[i], i == body.size() - 1);
        regions_queued++;
    endtask

    // Sender side and receiver stalls.
    always @(posedge clk)
    begin : drive_inputs
        step_t head;
        logic  send_valid;
        logic  write_valid;
        logic  take_ready;
        bit    tail;
        if (rst_n)
        begin
            send_valid = in_valid && !in_ready;
            write_valid = cfg_valid && !cfg_ready;
            tail = pending_steps.size() < TAIL_STEPS;

            // Pick new idling odds now and then, zero giving calm stretches.
            if (cycle_count % 64 == 0)
            begin
                in_idle_pct = 10 * $urandom_range(0, 3);
                out_stall_pct = 10 * $urandom_range(0, 3);
            end
            cycle_count++;

            if (!send_valid && !write_valid)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (pending_steps.size() != 0)
                begin
                    head = pending_steps[0];
                    case (head.kind)
                        STEP_BYTE:
                            if (!tail && $urandom_range(0, 99) < in_idle_pct)
                                gap_left = $urandom_range(1, 10) - 1;
                            else
                            begin
                                send_valid = 1'b1;
                                data_byte <= head.data;
                                last_byte <= head.last;
                                void'(pending_steps.pop_front());
                            end
                        STEP_WRITE:
                            if (idle_run >= SETTLE_CYCLES && !in_valid)
                            begin
                                write_valid = 1'b1;
                                cfg_index <= head.index;
                                cfg_data <= head.value;
                                void'(pending_steps.pop_front());
                            end
                        default:
                            if (idle_run >= SETTLE_CYCLES && !in_valid)
                                void'(pending_steps.pop_front());
                    endcase
                end
            end
            in_valid <= send_valid;
            cfg_valid <= write_valid;

            if (stall_left != 0)
            begin
                stall_left--;
                take_ready = 1'b0;
            end
            else if (!tail && $urandom_range(0, 99) < out_stall_pct)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                take_ready = 1'b0;
            end
            else
                take_ready = 1'b1;
            out_ready <= take_ready;
        end
    end

    // Check results, predict new ones and track register writes.
    always @(posedge clk)
    begin : check_outputs
        search_report_t want;
        bit             byte_taken;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                    report_mismatch($sformatf("unexpected result found=%0b address=%h",
                                              found, match_address));
                else
                begin
                    want = expected_reports.pop_front();
                    if (found !== want.found)
                        report_mismatch($sformatf("found %0b, predicted %0b",
                                                  found, want.found));
                    if (match_address !== want.addr)
                        report_mismatch($sformatf("match_address %h, predicted %h",
                                                  match_address, want.addr));
                    if (want.found)
                        hits_seen++;
                    else
                        misses_seen++;
                end
            end

            byte_taken = in_valid && in_ready;
            if (byte_taken)
            begin
                bytes_taken++;
                if (search_step(data_byte, last_byte, want))
                    expected_reports.push_back(want);
            end

            if (cfg_valid && cfg_ready)
            begin
                writes_taken++;
                case (cfg_index)
                    REG_PATTERN_LOW:    pat_low = cfg_data;
                    REG_PATTERN_HIGH:   pat_high = cfg_data;
                    REG_CARE_BITS:      care_reg = cfg_data[CARE_W-1:0];
                    REG_PATTERN_LENGTH: len_reg = cfg_data[LEN_W-1:0];
                    REG_REGION_BASE:    base_reg = cfg_data;
                    default:            ;
                endcase
            end

            idle_run <= (expected_reports.size() == 0 && !byte_taken) ? idle_run + 1 : 0;
        end
    end

    // Stimulus plan, reset and end of run.
    initial
    begin : run_plan
        logic [63:0] value;
        logic [LEN_W-1:0] new_len;
        int drain_at;
        int k;

        // Reset values: one wildcard byte matches at once, on the last byte.
        queue_byte(8'hFF, 1'b1);

        // Zero length acts as one; the match address wraps past the top.
        queue_write(REG_PATTERN_LENGTH, 64'd0);
        queue_write(REG_CARE_BITS, 64'h1);
        queue_write(REG_PATTERN_LOW, 64'hA5);
        queue_write(REG_REGION_BASE, '1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hA5, 1'b0);
        queue_byte(8'hFF, 1'b1);

        // Care bits above the length are ignored; a short region misses.
        queue_write(REG_CARE_BITS, 64'hFFF0);
        queue_write(REG_PATTERN_LENGTH, 64'd4);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_region(0, 1'b1, 1'b0, 0);

        // Oversize length clips to the full window; the whole region is the
        // pattern, so the match starts at the last possible position.
        queue_write(REG_PATTERN_LENGTH, 64'd31);
        queue_write(REG_CARE_BITS, '1);
        queue_write(REG_PATTERN_LOW, {$urandom, $urandom});
        queue_write(REG_PATTERN_HIGH, {$urandom, $urandom});
        queue_write(CFG_INDEX_W'($urandom_range(int'(REG_REGION_BASE) + 1,
                                                (1 << CFG_INDEX_W) - 1)),
                    {$urandom, $urandom});
        queue_write(REG_REGION_BASE, '0);
        queue_region(0, 1'b1, 1'b0, 0);

        // Random settings, each followed by a batch of regions.
        while (bytes_queued < RANDOM_ITEMS + 26)
        begin
            case ($urandom_range(0, 5))
                0:       new_len = LEN_W'(1);
                1:       new_len = LEN_W'(MAX_PATTERN_BYTES);
                2:       new_len = '0;
                3:       new_len = LEN_W'($urandom_range(MAX_PATTERN_BYTES + 1,
                                                         (1 << LEN_W) - 1));
                default: new_len = LEN_W'($urandom_range(2, MAX_PATTERN_BYTES - 1));
            endcase
            value = {$urandom, $urandom};
            value[LEN_W-1:0] = new_len;
            queue_write(REG_PATTERN_LENGTH, value);

            if ($urandom_range(0, 1))
            begin
                value = {$urandom, $urandom};
                case ($urandom_range(0, 3))
                    0:       value[CARE_W-1:0] = '0;
                    1:       value[CARE_W-1:0] = '1;
                    default: ;
                endcase
                queue_write(REG_CARE_BITS, value);
            end
            if ($urandom_range(0, 1))
                queue_write(REG_PATTERN_LOW, $urandom_range(0, 5) == 0 ? '1 :
                                             {$urandom, $urandom});
            if ($urandom_range(0, 1))
                queue_write(REG_PATTERN_HIGH, $urandom_range(0, 5) == 0 ? '0 :
                                              {$urandom, $urandom});
            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 3))
                    0:       value = '0;
                    1:       value = '1;
                    2:       value = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 40);
                    default: value = {$urandom, $urandom};
                endcase
                queue_write(REG_REGION_BASE, value);
            end

            drain_at = $urandom_range(0, 7);
            for (k = 0; k < 8; k++)
            begin
                if (k == drain_at)
                    queue_drain();
                queue_region($urandom_range(0, 12), $urandom_range(0, 9) < 7,
                             $urandom_range(0, 3) == 0, $urandom_range(0, 6));
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_steps.size() != 0 || in_valid || cfg_valid)
            @(negedge clk);
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES + 2) @(negedge clk);

        $display("Streamed %0d bytes in %0d regions with %0d register writes.",
                 bytes_taken, regions_queued, writes_taken);
        $display("Checked %0d reported matches and %0d regions without a match.",
                 hits_seen, misses_seen);
        if (mismatch_count == 0)
            $display("masked_byte_pattern_search: match");
        else
            $display("masked_byte_pattern_search: mismatch");
        $finish;
    end

endmodule
